FILE: rtl/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising clock edge outside reset.
`define B2SS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define B2SS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define B2SS_ASSERT(name, prop, msg)

`define B2SS_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

FILE: rtl/b2ss_pkg.sv
package b2ss_pkg;

  // Width of the binary input value.
  localparam int unsigned VALUE_W = 32;

  // Binary bits consumed by one double-dabble stage.
  localparam int unsigned STAGE_BITS = 4;
  localparam int unsigned NUM_STAGES = VALUE_W / STAGE_BITS;

  // Width of the digit position field.
  localparam int unsigned POS_W = 3;

  // Command kinds carried on the input tuser.
  localparam logic OP_NUMBER = 1'b0;
  localparam logic OP_ERROR  = 1'b1;

  // Bus address of the leftmost digit register.
  localparam logic [6:0] ADDR_BASE = 7'h64;

  // Number of characters in the error pattern.
  localparam int unsigned ERR_LEN = 5;

  // One display-register write, reg_address in the lowest bits.
  typedef struct packed {
    logic [POS_W-1:0] digit_pos;
    logic [7:0]       segments;
    logic [6:0]       reg_address;
  } out_word_t;

  // Seven-segment code of a decimal digit, bit 0 is segment a.
  function automatic logic [7:0] seg_of_digit(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h3f;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5b;
      4'd3:    seg = 8'h4f;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6d;
      4'd6:    seg = 8'h7d;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7f;
      4'd9:    seg = 8'h6f;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  // Character of the "Error" pattern at a position; blank past its end.
  function automatic logic [7:0] err_char(input logic [POS_W-1:0] pos);
    logic [7:0] seg;
    case (pos)
      3'd0:    seg = 8'h79;
      3'd1:    seg = 8'h50;
      3'd2:    seg = 8'h50;
      3'd3:    seg = 8'h5c;
      3'd4:    seg = 8'h50;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

FILE: rtl/b2ss_dd_stage.sv
// One pipeline stage of the binary to BCD conversion. It shifts
// STAGE_BITS binary bits into the BCD digits, with the add-three
// correction before each shift. Only the low DIGITS decimal digits are
// kept, which reduces the value modulo 10^DIGITS for free.
module b2ss_dd_stage
  import b2ss_pkg::*;
#(
  parameter int unsigned DIGITS = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic                  op_i,
  input  logic [VALUE_W-1:0]    bin_i,
  input  logic [4*DIGITS-1:0]   bcd_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic                  op_o,
  output logic [VALUE_W-1:0]    bin_o,
  output logic [4*DIGITS-1:0]   bcd_o
);

  localparam int unsigned BCD_W = 4 * DIGITS;

  logic               valid_q;
  logic               op_q;
  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;

  // The stage takes a new word when it is empty or its word moves on.
  assign ready_o = !valid_q || ready_i;

  // Double-dabble steps for this stage's slice of the binary value.
  always_comb begin
    bin_d = bin_i;
    bcd_d = bcd_i;
    for (int s = 0; s < STAGE_BITS; s++) begin
      for (int k = 0; k < DIGITS; k++) begin
        if (bcd_d[4*k +: 4] >= 4'd5) begin
          bcd_d[4*k +: 4] = bcd_d[4*k +: 4] + 4'd3;
        end
      end
      bcd_d = {bcd_d[BCD_W-2:0], bin_d[VALUE_W-1]};
      bin_d = {bin_d[VALUE_W-2:0], 1'b0};
    end
  end

  // Valid bit follows the handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload loads only with a valid word.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      op_q  <= op_i;
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;
  assign bin_o   = bin_q;
  assign bcd_o   = bcd_q;

endmodule

FILE: rtl/b2ss_serializer.sv
// Turns one converted command into DIGITS display-register writes,
// leftmost digit first, through a registered output word.
module b2ss_serializer
  import b2ss_pkg::*;
#(
  parameter int unsigned DIGITS = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic                op_i,
  input  logic [4*DIGITS-1:0] bcd_i,
  output logic                valid_o,
  input  logic                ready_i,
  output out_word_t           word_o,
  output logic                last_o
);

  localparam int unsigned BCD_W = 4 * DIGITS;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS - 1);

  logic             buf_valid_q;
  logic             buf_op_q;
  logic [BCD_W-1:0] buf_bcd_q;
  logic [POS_W-1:0] pos_q;
  logic             out_valid_q;
  out_word_t        out_word_q, out_word_d;
  logic             out_last_q;
  logic             load, emit, at_last, take;
  logic [3:0]       digit;

  // The output register loads when empty or when its word is taken.
  assign load    = !out_valid_q || ready_i;
  assign emit    = load && buf_valid_q;
  assign at_last = (pos_q == LAST_POS);
  assign ready_o = !buf_valid_q || (emit && at_last);
  assign take    = valid_i && ready_o;

  // The leading digit sits in the top nibble; the buffer shifts after each write.
  assign digit = buf_bcd_q[BCD_W-1 -: 4];

  always_comb begin
    out_word_d.digit_pos   = pos_q;
    out_word_d.reg_address = ADDR_BASE + {3'b000, pos_q, 1'b0};
    out_word_d.segments    = (buf_op_q == OP_ERROR) ? err_char(pos_q)
                                                    : seg_of_digit(digit);
  end

  // Command buffer and position counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      if (take) begin
        buf_valid_q <= 1'b1;
      end else if (emit && at_last) begin
        buf_valid_q <= 1'b0;
      end
      if (emit) begin
        pos_q <= at_last ? '0 : pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      buf_op_q  <= op_i;
      buf_bcd_q <= bcd_i;
    end else if (emit) begin
      buf_bcd_q <= buf_bcd_q << 4;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= buf_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_word_q <= out_word_d;
      out_last_q <= at_last;
    end
  end

  assign valid_o = out_valid_q;
  assign word_o  = out_word_q;
  assign last_o  = out_last_q;

endmodule

FILE: rtl/binary_to_seven_segment_writer_top.sv
// Seven-segment number writer. Each command word on the slave stream either
// shows a 32-bit unsigned value (tuser 0), reduced modulo 10^DIGITS, or the
// fixed pattern "Error" (tuser 1). It yields DIGITS display-register write
// words on the master stream, leftmost digit first, each with the register
// address 100 + 2 * position and the segment byte; the final word has tlast.
// The conversion runs through an eight-stage double-dabble pipeline, four
// bits per stage, followed by a command buffer and the output register. The
// output side moves one write word per cycle while the master stream does not
// stall; the serializer that emits the writes takes the next command as it
// emits the last write of the current one, and commands are accepted in
// consecutive cycles until the pipeline fills.
`include "assert_macros.svh"

module binary_to_seven_segment_writer_top
  import b2ss_pkg::*;
#(
  parameter int unsigned DIGITS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: value[31:0]
  input  logic [31:0] s_axis_tdata,
  // tuser: op[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: reg_address[6:0], segments[14:7], digit_pos[17:15], zero[23:18]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);

  localparam int unsigned BCD_W = 4 * DIGITS;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS - 1);

  logic               stg_valid [NUM_STAGES+1];
  logic               stg_ready [NUM_STAGES+1];
  logic               stg_op    [NUM_STAGES+1];
  logic [VALUE_W-1:0] stg_bin   [NUM_STAGES+1];
  logic [BCD_W-1:0]   stg_bcd   [NUM_STAGES+1];
  out_word_t          out_word;

  // Pipeline entry from the slave stream.
  assign stg_valid[0]  = s_axis_tvalid;
  assign s_axis_tready = stg_ready[0];
  assign stg_op[0]     = s_axis_tuser;
  assign stg_bin[0]    = s_axis_tdata;
  assign stg_bcd[0]    = '0;

  // Double-dabble pipeline.
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    b2ss_dd_stage #(
      .DIGITS (DIGITS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[g]),
      .ready_o (stg_ready[g]),
      .op_i    (stg_op[g]),
      .bin_i   (stg_bin[g]),
      .bcd_i   (stg_bcd[g]),
      .valid_o (stg_valid[g+1]),
      .ready_i (stg_ready[g+1]),
      .op_o    (stg_op[g+1]),
      .bin_o   (stg_bin[g+1]),
      .bcd_o   (stg_bcd[g+1])
    );
  end

  // Write sequencer and output register.
  b2ss_serializer #(
    .DIGITS (DIGITS)
  ) u_serializer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid[NUM_STAGES]),
    .ready_o (stg_ready[NUM_STAGES]),
    .op_i    (stg_op[NUM_STAGES]),
    .bcd_i   (stg_bcd[NUM_STAGES]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .word_o  (out_word),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b000000, out_word};

  // Signals observed by the checks below.
  logic             conv_valid, conv_ready, out_is_last;
  logic [POS_W-1:0] out_pos;
  logic [6:0]       out_addr, exp_addr;

  assign conv_valid  = stg_valid[NUM_STAGES];
  assign conv_ready  = stg_ready[NUM_STAGES];
  assign out_is_last = m_axis_tvalid && m_axis_tlast;
  assign out_pos     = m_axis_tdata[17:15];
  assign out_addr    = m_axis_tdata[6:0];
  assign exp_addr    = ADDR_BASE + {3'b000, out_pos, 1'b0};

  // A converted word held back by the serializer stays at the pipeline end.
  `B2SS_ASSERT(a_pipe_hold, conv_valid && !conv_ready |=> conv_valid, "pipeline word lost")

  // The last write of a command is at the rightmost position.
  `B2SS_ASSERT(a_last_pos, out_is_last |-> out_pos == LAST_POS, "tlast off the last digit")

  // The register address always follows the digit position.
  `B2SS_ASSERT(a_addr_pos, m_axis_tvalid |-> out_addr == exp_addr, "address off position")

endmodule

FILE: sim/binary_to_seven_segment_writer_top_test.sv
module binary_to_seven_segment_writer_top_test;
  import b2ss_pkg::*;

  localparam int unsigned DIGIT_COUNT = 5;
  localparam int unsigned RANDOM_CMDS = 250;
  localparam int unsigned STEADY_TAIL = 40;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned PRINT_LIMIT = 60;

  // Values shown wrap at ten to the number of digits.
  localparam longint unsigned DISPLAY_RANGE = 64'd10 ** DIGIT_COUNT;
  localparam longint unsigned WRAP_STEPS = 64'hFFFF_FFFF / DISPLAY_RANGE;

  // Segment bytes, digit 0 and pattern position 0 in the lowest byte.
  localparam logic [79:0] DIGIT_GLYPHS = {8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d,
                                          8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};
  localparam logic [39:0] ERROR_GLYPHS = 40'h50_5c_50_50_79;

  // One expected display-register write.
  typedef struct packed {
    logic      last;
    out_word_t word;
  } digit_write_t;

  // Segment bytes typed in by hand for a command, position 0 lowest.
  typedef struct packed {
    logic        known;
    logic [39:0] glyphs;
  } glyph_hint_t;

  // One row of the directed command table.
  typedef struct packed {
    logic        op;
    logic [31:0] value;
    logic        known;
    logic [39:0] glyphs;
  } cmd_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = OP_NUMBER;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;

  digit_write_t pending_writes[$];
  glyph_hint_t  cmd_hints[$];
  int unsigned  errors = 0;
  int unsigned  writes_seen = 0;
  int unsigned  idle_cycles = 0;
  logic         steady_flow = 1'b0;

  binary_to_seven_segment_writer_top #(
    .DIGITS(DIGIT_COUNT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  // Free-running clock with a period of two time units.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Queue the writes one accepted command should produce, leftmost digit first.
  function automatic void predict_digit_writes(input logic op, input logic [31:0] value,
                                               input glyph_hint_t hint);
    longint unsigned rest;
    longint unsigned scale;
    logic [3:0]      digit;
    digit_write_t    w;
    rest  = value % DISPLAY_RANGE;
    scale = DISPLAY_RANGE / 10;
    for (int unsigned pos = 0; pos < DIGIT_COUNT; pos++) begin
      digit = 4'((rest / scale) % 10);
      scale = scale / 10;
      w.word.reg_address = ADDR_BASE + 7'(2 * pos);
      w.word.digit_pos   = POS_W'(pos);
      w.last             = (pos == DIGIT_COUNT - 1);
      if (hint.known) begin
        w.word.segments = hint.glyphs[8*pos +: 8];
      end else if (op == OP_ERROR) begin
        // The pattern is blank past its fifth character.
        w.word.segments = (pos < ERR_LEN) ? ERROR_GLYPHS[8*pos +: 8] : 8'h00;
      end else begin
        w.word.segments = DIGIT_GLYPHS[8*digit +: 8];
      end
      pending_writes.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= PRINT_LIMIT) begin
      $display("write %0d: %s is 0x%0h, expected 0x%0h", writes_seen, field, got, want);
    end
  endtask

  // Predict on accepted commands and compare every accepted write.
  always @(posedge clk_i) begin : write_check
    digit_write_t want;
    out_word_t    got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_digit_writes(s_axis_tuser, s_axis_tdata, cmd_hints.pop_front());
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[17:0];
        if (pending_writes.size() == 0) begin
          report_mismatch("unrequested word", m_axis_tdata, '0);
        end else begin
          want = pending_writes.pop_front();
          if (got.reg_address != want.word.reg_address) begin
            report_mismatch("reg_address", got.reg_address, want.word.reg_address);
          end
          if (got.segments != want.word.segments) begin
            report_mismatch("segments", got.segments, want.word.segments);
          end
          if (got.digit_pos != want.word.digit_pos) begin
            report_mismatch("digit_pos", got.digit_pos, want.word.digit_pos);
          end
          if (m_axis_tlast != want.last) begin
            report_mismatch("tlast", m_axis_tlast, want.last);
          end
          if (m_axis_tdata[23:18] != '0) begin
            report_mismatch("padding", m_axis_tdata[23:18], '0);
          end
        end
        writes_seen++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Ends the run when neither side has moved a word for too long.
  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // Receiver stalls in random bursts unless the flow is held steady.
  initial begin : sink_stalls
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!steady_flow && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Present one command word and return at the edge that accepts it.
  task automatic send_cmd(input logic op, input logic [31:0] value, input glyph_hint_t hint);
    cmd_hints.push_back(hint);
    s_axis_tdata  <= value;
    s_axis_tuser  <= op;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sometimes leave a gap before the next command, unless the flow is held steady.
  task automatic sender_gap();
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every queued write has come out.
  task automatic drain_writes();
    s_axis_tvalid <= 1'b0;
    while (pending_writes.size() != 0 || cmd_hints.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    cmd_row_t    rows [20];
    logic        op;
    logic [31:0] value;

    // Rows with known set carry the segment bytes to expect, position 0 lowest.
    rows = '{
      '{OP_NUMBER, 32'd0,          1'b1, 40'h3f_3f_3f_3f_3f},
      '{OP_NUMBER, 32'd99999,      1'b1, 40'h6f_6f_6f_6f_6f},
      '{OP_NUMBER, 32'd100000,     1'b1, 40'h3f_3f_3f_3f_3f},
      '{OP_NUMBER, 32'hFFFF_FFFF,  1'b1, 40'h6d_6f_5b_07_7d},
      '{OP_ERROR,  32'd0,          1'b1, ERROR_GLYPHS},
      '{OP_ERROR,  32'hFFFF_FFFF,  1'b1, ERROR_GLYPHS},
      '{OP_ERROR,  32'd12345,      1'b1, ERROR_GLYPHS},
      '{OP_NUMBER, 32'd1,          1'b0, 40'h0},
      '{OP_NUMBER, 32'd12345,      1'b0, 40'h0},
      '{OP_NUMBER, 32'd67890,      1'b0, 40'h0},
      '{OP_NUMBER, 32'd100001,     1'b0, 40'h0},
      '{OP_NUMBER, 32'd199999,     1'b0, 40'h0},
      '{OP_NUMBER, 32'h8000_0000,  1'b0, 40'h0},
      '{OP_NUMBER, 32'd9,          1'b0, 40'h0},
      '{OP_NUMBER, 32'd10,         1'b0, 40'h0},
      '{OP_NUMBER, 32'hFFFE_F91F,  1'b0, 40'h0},
      '{OP_NUMBER, 32'hFFFE_F920,  1'b0, 40'h0},
      '{OP_NUMBER, 32'd24680,      1'b0, 40'h0},
      '{OP_NUMBER, 32'h5555_AAAA,  1'b0, 40'h0},
      '{OP_ERROR,  32'h0000_0001,  1'b0, 40'h0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed commands: extremes, wrap-around and the error pattern.
    foreach (rows[i]) begin
      if (i == 10) begin
        drain_writes();
      end
      send_cmd(rows[i].op, rows[i].value, '{rows[i].known, rows[i].glyphs});
      sender_gap();
    end
    drain_writes();

    // Random commands, mixing full-range, in-range, wrap-edge and tiny values.
    for (int unsigned i = 0; i < RANDOM_CMDS; i++) begin
      steady_flow = ((i / 40) % 3 == 2) || (i >= RANDOM_CMDS - STEADY_TAIL);
      if (i == 120) begin
        drain_writes();
      end
      case ($urandom_range(0, 3))
        0: value = $urandom();
        1: value = 32'($urandom_range(0, 32'(DISPLAY_RANGE - 1)));
        2: value = 32'(longint'($urandom_range(0, 32'(WRAP_STEPS - 1))) * DISPLAY_RANGE
                       + ($urandom_range(0, 1) ? DISPLAY_RANGE - 1 : 0));
        default: value = $urandom_range(0, 99);
      endcase
      op = ($urandom_range(0, 7) == 0) ? OP_ERROR : OP_NUMBER;
      send_cmd(op, value, '{1'b0, 40'h0});
      sender_gap();
    end

    // Let the last writes drain, then wait SETTLE_CYCLES longer for strays.
    s_axis_tvalid <= 1'b0;
    while (pending_writes.size() != 0 || cmd_hints.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/b2ss_pkg.sv
rtl/b2ss_dd_stage.sv
rtl/b2ss_serializer.sv
rtl/binary_to_seven_segment_writer_top.sv
sim/binary_to_seven_segment_writer_top_test.sv
